/* rtl/core/eca_pkg.sv */
// Package: sizes, codes, command type and row functions for the automaton row generator.
package eca_pkg;

  localparam int ROW_CELLS  = 160;
  localparam int MAX_GENS   = 110;
  localparam int CHUNK_BITS = 32;
  localparam int NUM_CHUNKS = (ROW_CELLS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int PAD_CELLS  = NUM_CHUNKS * CHUNK_BITS;

  localparam int ROW_IDX_W   = 7;
  localparam int CHUNK_IDX_W = 3;
  localparam int GEN_W       = $clog2(MAX_GENS + 1);

  localparam logic [7:0] RULE_RESET    = 8'h1e;
  localparam logic [7:0] DRAW_MATCH    = 8'd128;
  localparam logic [3:0] MUTATE_PERIOD = 4'd8;

  // Item mode codes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  // Mutation mode codes
  localparam logic [1:0] MUT_RANDOM = 2'd0;
  localparam logic [1:0] MUT_EIGHTH = 2'd1;
  localparam logic [1:0] MUT_NONE   = 2'd2;

  // Seed mode codes
  localparam logic SEED_ALTERNATE = 1'b0;
  localparam logic SEED_CENTER    = 1'b1;

  // Register indexes
  localparam logic [1:0] CFG_RULE_BYTE   = 2'd0;
  localparam logic [1:0] CFG_SEED_MODE   = 2'd1;
  localparam logic [1:0] CFG_MUTATE_MODE = 2'd2;

  typedef enum logic {OP_SEED, OP_STEP} cmd_op_t;

  typedef struct packed {
    cmd_op_t              op;
    logic [7:0]           rule;
    logic [ROW_IDX_W-1:0] row_no;
  } cmd_t;

  typedef struct packed {
    logic reseed;
    logic seed_mode;
  } seed_ctrl_t;

  function automatic logic [ROW_CELLS-1:0] seed_row(input logic mode);
    logic [ROW_CELLS-1:0] r;
    for (int i = 0; i < ROW_CELLS; i++) begin
      r[i] = mode ? 1'b0 : i[0];
    end
    if (mode) begin
      r[ROW_CELLS/2] = 1'b1;
    end
    return r;
  endfunction

  // Pattern bit 2 is the lower-index neighbor, bit 0 the higher-index one.
  function automatic logic [ROW_CELLS-1:0] next_row(input logic [ROW_CELLS-1:0] r,
                                                   input logic [7:0] rule);
    logic [ROW_CELLS+1:0] ext;
    logic [ROW_CELLS-1:0] f;
    ext = {1'b0, r, 1'b0};
    for (int i = 0; i < ROW_CELLS; i++) begin
      f[i] = rule[{ext[i], ext[i+1], ext[i+2]}];
    end
    return f;
  endfunction

endpackage

/* rtl/core/eca_if.sv */
// Interfaces: input item channel, result channel and configuration write channel.
interface eca_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] mutate_draw;
  logic [7:0] next_rule;
  modport source (output valid, mode, mutate_draw, next_rule, input ready);
  modport sink   (input valid, mode, mutate_draw, next_rule, output ready);
endinterface

interface eca_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  row_index;
  logic [2:0]  chunk_index;
  logic [31:0] cell_bits;
  logic [7:0]  rule_used;
  logic        last_chunk;
  modport source (output valid, row_index, chunk_index, cell_bits, rule_used, last_chunk,
                  input ready);
  modport sink   (input valid, row_index, chunk_index, cell_bits, rule_used, last_chunk,
                  output ready);
endinterface

interface eca_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/elementary_ca_row_generator.sv */
// Top level: elementary cellular automaton row generator.
// Keeps a 160-cell row (cells beyond either end read dead) and emits every
// generation as five 32-bit chunks, lowest chunk first, one beat per cycle
// when the sink is ready. A start item seeds the row and emits generation 0;
// a tick item (while 0 < count < 110) optionally mutates the rule and emits
// the next generation; stop ends the run. The next row is computed in the
// same cycle the last chunk of the previous row leaves, so queued rows stream
// with no gap. Stop, unused modes and ignored ticks push no row command. A
// two-entry command queue sits between the front end (which accepts items
// while chunks are still streaming) and the row engine.
// Config writes are always taken; write only while the block is idle.
module elementary_ca_row_generator (
  input  logic     clk,
  input  logic     rst,
  eca_in_if.sink   items,
  eca_out_if.source chunks,
  eca_cfg_if.sink  cfg
);
  import eca_pkg::*;

  cmd_t       push_cmd;
  cmd_t       head;
  seed_ctrl_t seed_ctrl;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_not_empty;
  logic [1:0] q_count;

  // Config port never stalls
  assign cfg.ready = 1'b1;

  eca_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (items.valid),
    .in_mode      (items.mode),
    .in_draw      (items.mutate_draw),
    .in_next_rule (items.next_rule),
    .in_ready     (items.ready),
    .cfg_valid    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .q_full       (q_full),
    .push         (push),
    .push_cmd     (push_cmd),
    .seed_ctrl    (seed_ctrl)
  );

  eca_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full),
    .count     (q_count)
  );

  eca_back u_back (
    .clk             (clk),
    .rst             (rst),
    .seed_ctrl       (seed_ctrl),
    .head            (head),
    .q_not_empty     (q_not_empty),
    .pop             (pop),
    .out_valid       (chunks.valid),
    .out_ready       (chunks.ready),
    .out_row_index   (chunks.row_index),
    .out_chunk_index (chunks.chunk_index),
    .out_cell_bits   (chunks.cell_bits),
    .out_rule        (chunks.rule_used),
    .out_last        (chunks.last_chunk)
  );

  // Queue never overflows: the front end holds off while it is full
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    !(q_count == 2'd2 && push && !pop))
    else $error("command queue overflow");

  // A taken non-final beat is followed by the next chunk of the same row
  a_chunk_order: assert property (@(posedge clk) disable iff (rst)
    (chunks.valid && chunks.ready && !chunks.last_chunk) |=>
      (chunks.valid && chunks.chunk_index == $past(chunks.chunk_index) + 3'd1
       && chunks.row_index == $past(chunks.row_index)))
    else $error("chunk sequence broken");

  // Emitted generation stays below the limit
  a_row_limit: assert property (@(posedge clk) disable iff (rst)
    chunks.valid |-> (chunks.row_index < ROW_IDX_W'(MAX_GENS)))
    else $error("row index beyond generation limit");

endmodule

/* rtl/core/eca_front.sv */
// Front end: accepts items and config writes, tracks run state, issues row commands.
module eca_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_mode,
  input  logic [7:0]          in_draw,
  input  logic [7:0]          in_next_rule,
  output logic                in_ready,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                q_full,
  output logic                push,
  output eca_pkg::cmd_t       push_cmd,
  output eca_pkg::seed_ctrl_t seed_ctrl
);
  import eca_pkg::*;

  logic [GEN_W-1:0] gen_count, gen_count_next;
  logic [7:0]       active_rule, active_rule_next;
  logic [3:0]       mut_cnt, mut_cnt_next;
  logic             seed_mode;
  logic [1:0]       mutate_mode;
  logic             accept;
  logic             tick_ok;
  logic [3:0]       mut_inc;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign tick_ok  = (gen_count != '0) && (gen_count < GEN_W'(MAX_GENS));
  assign mut_inc  = mut_cnt + 4'd1;

  always_comb begin
    gen_count_next   = gen_count;
    active_rule_next = active_rule;
    mut_cnt_next     = mut_cnt;
    push             = 1'b0;
    push_cmd.op      = OP_SEED;
    push_cmd.rule    = active_rule;
    push_cmd.row_no  = '0;
    if (accept) begin
      case (in_mode)
        MODE_START: begin
          gen_count_next = GEN_W'(1);
          push           = 1'b1;
        end
        MODE_STOP: begin
          gen_count_next = GEN_W'(MAX_GENS);
        end
        MODE_TICK: begin
          if (tick_ok) begin
            // mutate first, then the new row uses the updated rule
            if (mutate_mode == MUT_EIGHTH) begin
              mut_cnt_next = mut_inc;
              if (mut_inc == MUTATE_PERIOD) begin
                active_rule_next = in_next_rule;
                mut_cnt_next     = '0;
              end
            end else if (mutate_mode == MUT_RANDOM) begin
              if (in_draw == DRAW_MATCH) begin
                active_rule_next = in_next_rule;
              end
            end
            push            = 1'b1;
            push_cmd.op     = OP_STEP;
            push_cmd.rule   = active_rule_next;
            push_cmd.row_no = ROW_IDX_W'(gen_count);
            gen_count_next  = gen_count + GEN_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
    if (cfg_valid && cfg_index == CFG_RULE_BYTE) begin
      active_rule_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_count   <= '0;
      active_rule <= RULE_RESET;
      mut_cnt     <= 4'd1;
      seed_mode   <= SEED_CENTER;
      mutate_mode <= MUT_NONE;
    end else begin
      gen_count   <= gen_count_next;
      active_rule <= active_rule_next;
      mut_cnt     <= mut_cnt_next;
      if (cfg_valid && cfg_index == CFG_SEED_MODE) begin
        seed_mode <= cfg_data[0];
      end
      if (cfg_valid && cfg_index == CFG_MUTATE_MODE) begin
        mutate_mode <= cfg_data[1:0];
      end
    end
  end

  assign seed_ctrl.reseed    = cfg_valid && cfg_index == CFG_SEED_MODE;
  assign seed_ctrl.seed_mode = seed_ctrl.reseed ? cfg_data[0] : seed_mode;

endmodule

/* rtl/core/eca_queue.sv */
// Two-entry command queue between front and back.
module eca_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  eca_pkg::cmd_t push_cmd,
  input  logic          pop,
  output eca_pkg::cmd_t head,
  output logic          not_empty,
  output logic          full,
  output logic [1:0]    count
);
  import eca_pkg::*;

  cmd_t entries [2];
  logic wr_ptr;
  logic rd_ptr;

  assign not_empty = count != 2'd0;
  assign full      = count == 2'd2;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* rtl/core/eca_back.sv */
// Back end: holds the cell row, applies seed and step commands, streams chunks.
module eca_back (
  input  logic                         clk,
  input  logic                         rst,
  input  eca_pkg::seed_ctrl_t          seed_ctrl,
  input  eca_pkg::cmd_t                head,
  input  logic                         q_not_empty,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [eca_pkg::ROW_IDX_W-1:0]   out_row_index,
  output logic [eca_pkg::CHUNK_IDX_W-1:0] out_chunk_index,
  output logic [eca_pkg::CHUNK_BITS-1:0]  out_cell_bits,
  output logic [7:0]                   out_rule,
  output logic                         out_last
);
  import eca_pkg::*;

  logic [ROW_CELLS-1:0]   cells;
  logic [PAD_CELLS-1:0]   padded;
  logic                   busy;
  logic [CHUNK_IDX_W-1:0] chunk;
  logic [ROW_IDX_W-1:0]   row_no;
  logic [7:0]             rule;
  logic                   last;

  assign last   = chunk == CHUNK_IDX_W'(NUM_CHUNKS - 1);
  assign pop    = q_not_empty && (!busy || (out_ready && last));
  assign padded = PAD_CELLS'(cells);

  always_ff @(posedge clk) begin
    if (rst) begin
      cells <= seed_row(SEED_CENTER);
    end else if (seed_ctrl.reseed) begin
      cells <= seed_row(seed_ctrl.seed_mode);
    end else if (pop) begin
      cells <= (head.op == OP_SEED) ? seed_row(seed_ctrl.seed_mode)
                                    : next_row(cells, head.rule);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      row_no <= head.row_no;
      rule   <= head.rule;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      chunk <= '0;
    end else if (pop) begin
      busy  <= 1'b1;
      chunk <= '0;
    end else if (busy && out_ready) begin
      // advance to the next chunk, or drop out when the row is done
      if (last) begin
        busy <= 1'b0;
      end else begin
        chunk <= chunk + CHUNK_IDX_W'(1);
      end
    end
  end

  assign out_valid       = busy;
  assign out_row_index   = row_no;
  assign out_chunk_index = chunk;
  assign out_cell_bits   = padded[chunk * CHUNK_BITS +: CHUNK_BITS];
  assign out_rule        = rule;
  assign out_last        = last;

endmodule
